// ===== hw/rtl/suction_gripper_store_sequencer_top_assert.svh =====
// Assertion macros for the suction gripper store sequencer checker.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef SUCTION_GRIPPER_STORE_SEQUENCER_TOP_ASSERT_SVH
`define SUCTION_GRIPPER_STORE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define SGSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sgss_pkg.sv =====
// Shared types and codes for the suction gripper store sequencer.
// No dependencies.
package sgss_pkg;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_PICKUP      = 3'd1,
        PH_WAIT_ATTACH = 3'd2,
        PH_STORE       = 3'd3,
        PH_DROP        = 3'd4,
        PH_WAIT_DETACH = 3'd5,
        PH_STANDBY     = 3'd6,
        PH_DONE        = 3'd7
    } phase_t;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_STORE = 2'd1;
    localparam logic [1:0] FUNC_DROP  = 2'd2;

    localparam logic [2:0] POSE_NONE    = 3'd0;
    localparam logic [2:0] POSE_PICKUP  = 3'd1;
    localparam logic [2:0] POSE_STORE   = 3'd2;
    localparam logic [2:0] POSE_DROP    = 3'd3;
    localparam logic [2:0] POSE_STANDBY = 3'd4;

    localparam logic [2:0] RC_NONE        = 3'd0;
    localparam logic [2:0] RC_BUSY        = 3'd1;
    localparam logic [2:0] RC_NOT_READY   = 3'd2;
    localparam logic [2:0] RC_HOLDING     = 3'd3;
    localparam logic [2:0] RC_MISSING     = 3'd4;
    localparam logic [2:0] RC_PLAN_FAILED = 3'd5;

    localparam logic [1:0] CFG_ACTION_ENABLE = 2'd0;
    localparam logic [1:0] CFG_ATTACH_DELAY  = 2'd1;
    localparam logic [1:0] CFG_DETACH_DELAY  = 2'd2;

    localparam logic        ACTION_ENABLE_RST = 1'b1;
    localparam logic [15:0] ATTACH_DELAY_RST  = 16'd200;
    localparam logic [15:0] DETACH_DELAY_RST  = 16'd200;

    typedef struct packed {
        logic        action_enable;
        logic [15:0] attach_delay_ms;
        logic [15:0] detach_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        arm_ready;
        logic        arm_done;
        logic        plan_ok;
        logic        can_detect;
        logic        object_sensed;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic        failed;
        logic        holding;
        logic [31:0] wait_start_ms;
        logic        pump_on;
    } state_t;

    typedef struct packed {
        logic [2:0] phase_code;
        logic       failed_flag;
        logic       suction_on;
        logic [2:0] pose_request;
        logic       arm_stop;
        logic [2:0] report_code;
        logic       holding_assumed;
        logic       running;
    } result_t;

endpackage

// ===== hw/rtl/suction_gripper_store_sequencer_top.sv =====
// Suction gripper store sequencer, top level.
// Each item passes through an input register, then the result register.
// 1 item per cycle while the output is not stalled; state is updated as an item moves into the result register.
// Reset (rst_n low, async): phase idle, flags and pump clear, wait start 0,
// action_enable 1, both delays 200 ms, pipeline empty.
// Depends on sgss_pkg and sgss_step.
module suction_gripper_store_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] now_ms,
    input  logic        arm_ready,
    input  logic        arm_done,
    input  logic        plan_ok,
    input  logic        can_detect,
    input  logic        object_sensed,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  phase_code,
    output logic        failed_flag,
    output logic        suction_on,
    output logic [2:0]  pose_request,
    output logic        arm_stop,
    output logic [2:0]  report_code,
    output logic        holding_assumed,
    output logic        running
);

    sgss_pkg::cfg_t    cfg_reg;
    sgss_pkg::cfg_t    cfg_next;
    sgss_pkg::state_t  state_reg;
    sgss_pkg::state_t  state_next;
    sgss_pkg::item_t   item_reg;
    sgss_pkg::result_t res_reg;
    sgss_pkg::result_t step_res;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              in_take;

    // config writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                sgss_pkg::CFG_ACTION_ENABLE: cfg_next.action_enable   = cfg_data[0];
                sgss_pkg::CFG_ATTACH_DELAY:  cfg_next.attach_delay_ms = cfg_data;
                sgss_pkg::CFG_DETACH_DELAY:  cfg_next.detach_delay_ms = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    sgss_step u_step
    (
        .st      (state_reg),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.action_enable   <= sgss_pkg::ACTION_ENABLE_RST;
            cfg_reg.attach_delay_ms <= sgss_pkg::ATTACH_DELAY_RST;
            cfg_reg.detach_delay_ms <= sgss_pkg::DETACH_DELAY_RST;
            state_reg.phase         <= sgss_pkg::PH_IDLE;
            state_reg.failed        <= 1'b0;
            state_reg.holding       <= 1'b0;
            state_reg.wait_start_ms <= 32'd0;
            state_reg.pump_on       <= 1'b0;
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func          <= func;
            item_reg.now_ms        <= now_ms;
            item_reg.arm_ready     <= arm_ready;
            item_reg.arm_done      <= arm_done;
            item_reg.plan_ok       <= plan_ok;
            item_reg.can_detect    <= can_detect;
            item_reg.object_sensed <= object_sensed;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign phase_code      = res_reg.phase_code;
    assign failed_flag     = res_reg.failed_flag;
    assign suction_on      = res_reg.suction_on;
    assign pose_request    = res_reg.pose_request;
    assign arm_stop        = res_reg.arm_stop;
    assign report_code     = res_reg.report_code;
    assign holding_assumed = res_reg.holding_assumed;
    assign running         = res_reg.running;

endmodule

// ===== hw/rtl/sgss_step.sv =====
// Next-state and result logic for one item of the gripper sequencer.
// Depends on sgss_pkg.
module sgss_step
(
    input  sgss_pkg::state_t  st,
    input  sgss_pkg::item_t   item,
    input  sgss_pkg::cfg_t    cfg,
    output sgss_pkg::state_t  st_next,
    output sgss_pkg::result_t res
);

    logic        running_now;
    logic        held;
    logic [31:0] elapsed;
    logic        attach_ok;
    logic        detach_ok;
    logic [2:0]  pose;
    logic        stop;
    logic [2:0]  code;

    assign running_now = (st.phase != sgss_pkg::PH_IDLE) && (st.phase != sgss_pkg::PH_DONE);
    assign held        = item.can_detect ? item.object_sensed : st.holding;
    assign elapsed     = item.now_ms - st.wait_start_ms;
    assign attach_ok   = item.can_detect ? item.object_sensed
                                         : (elapsed >= {16'd0, cfg.attach_delay_ms});
    assign detach_ok   = item.can_detect ? !item.object_sensed
                                         : (elapsed >= {16'd0, cfg.detach_delay_ms});

    always_comb
    begin
        st_next = st;
        pose    = sgss_pkg::POSE_NONE;
        stop    = 1'b0;
        code    = sgss_pkg::RC_NONE;
        case (item.func)
            sgss_pkg::FUNC_TICK:
            begin
                case (st.phase)
                    sgss_pkg::PH_PICKUP:
                    begin
                        if (item.arm_done)
                        begin
                            st_next.wait_start_ms = item.now_ms;
                            st_next.phase         = sgss_pkg::PH_WAIT_ATTACH;
                        end
                    end
                    sgss_pkg::PH_WAIT_ATTACH:
                    begin
                        if (attach_ok)
                        begin
                            st_next.holding = 1'b1;
                            pose            = sgss_pkg::POSE_STORE;
                            if (item.plan_ok)
                            begin
                                st_next.phase = sgss_pkg::PH_STORE;
                            end
                            else
                            begin
                                stop           = 1'b1;
                                code           = sgss_pkg::RC_PLAN_FAILED;
                                st_next.phase  = sgss_pkg::PH_DONE;
                                st_next.failed = 1'b1;
                            end
                        end
                    end
                    sgss_pkg::PH_STORE,
                    sgss_pkg::PH_STANDBY:
                    begin
                        if (item.arm_done)
                        begin
                            st_next.phase = sgss_pkg::PH_DONE;
                        end
                    end
                    sgss_pkg::PH_DROP:
                    begin
                        if (item.arm_done)
                        begin
                            st_next.pump_on       = 1'b0;
                            st_next.wait_start_ms = item.now_ms;
                            st_next.phase         = sgss_pkg::PH_WAIT_DETACH;
                        end
                    end
                    sgss_pkg::PH_WAIT_DETACH:
                    begin
                        if (detach_ok)
                        begin
                            st_next.holding = 1'b0;
                            pose            = sgss_pkg::POSE_STANDBY;
                            if (item.plan_ok)
                            begin
                                st_next.phase = sgss_pkg::PH_STANDBY;
                            end
                            else
                            begin
                                stop           = 1'b1;
                                code           = sgss_pkg::RC_PLAN_FAILED;
                                st_next.phase  = sgss_pkg::PH_DONE;
                                st_next.failed = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            sgss_pkg::FUNC_STORE:
            begin
                if (!cfg.action_enable || running_now || !item.arm_ready)
                begin
                    code = running_now ? sgss_pkg::RC_BUSY : sgss_pkg::RC_NOT_READY;
                end
                else if (held)
                begin
                    code = sgss_pkg::RC_HOLDING;
                end
                else
                begin
                    st_next.failed  = 1'b0;
                    st_next.holding = 1'b0;
                    pose            = sgss_pkg::POSE_PICKUP;
                    if (item.plan_ok)
                    begin
                        st_next.pump_on = 1'b1;
                        st_next.phase   = sgss_pkg::PH_PICKUP;
                    end
                    else
                    begin
                        st_next.pump_on = 1'b0;
                        stop            = 1'b1;
                        code            = sgss_pkg::RC_PLAN_FAILED;
                        st_next.phase   = sgss_pkg::PH_DONE;
                        st_next.failed  = 1'b1;
                    end
                end
            end
            sgss_pkg::FUNC_DROP:
            begin
                if (!cfg.action_enable || running_now || !item.arm_ready)
                begin
                    code = running_now ? sgss_pkg::RC_BUSY : sgss_pkg::RC_NOT_READY;
                end
                else if (!held)
                begin
                    code = sgss_pkg::RC_MISSING;
                end
                else
                begin
                    st_next.failed = 1'b0;
                    pose           = sgss_pkg::POSE_DROP;
                    if (item.plan_ok)
                    begin
                        st_next.phase = sgss_pkg::PH_DROP;
                    end
                    else
                    begin
                        stop           = 1'b1;
                        code           = sgss_pkg::RC_PLAN_FAILED;
                        st_next.phase  = sgss_pkg::PH_DONE;
                        st_next.failed = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.phase_code      = st_next.phase;
        res.failed_flag     = st_next.failed;
        res.suction_on      = st_next.pump_on;
        res.pose_request    = pose;
        res.arm_stop        = stop;
        res.report_code     = code;
        res.holding_assumed = st_next.holding;
        res.running         = (st_next.phase != sgss_pkg::PH_IDLE) &&
                              (st_next.phase != sgss_pkg::PH_DONE);
    end

endmodule

// ===== hw/rtl/sgss_checker.sv =====
// Port-level checker for the suction gripper store sequencer, bound to the top level.
// Depends on sgss_pkg and suction_gripper_store_sequencer_top_assert.svh.
`include "suction_gripper_store_sequencer_top_assert.svh"

module sgss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] phase_code,
    input logic       failed_flag,
    input logic [2:0] pose_request,
    input logic       arm_stop,
    input logic [2:0] report_code,
    input logic       running
);

    `SGSS_ASSERT_NOW(a_running_matches_phase, out_valid, running == ((phase_code != sgss_pkg::PH_IDLE) && (phase_code != sgss_pkg::PH_DONE)), "running flag disagrees with phase")
    `SGSS_ASSERT_NOW(a_stop_means_failed_done, out_valid && arm_stop, (report_code == sgss_pkg::RC_PLAN_FAILED) && (phase_code == sgss_pkg::PH_DONE) && failed_flag && (pose_request != sgss_pkg::POSE_NONE), "stop pulse without a failed plan")
    `SGSS_ASSERT_NOW(a_refusal_has_no_pose, out_valid && (report_code != sgss_pkg::RC_NONE) && (report_code != sgss_pkg::RC_PLAN_FAILED), (pose_request == sgss_pkg::POSE_NONE) && !arm_stop, "refused item requested a move")
    `SGSS_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall, out_valid && $stable(phase_code) && $stable(report_code) && $stable(pose_request), "stalled result changed")

endmodule

bind suction_gripper_store_sequencer_top sgss_checker u_sgss_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phase_code   (phase_code),
    .failed_flag  (failed_flag),
    .pose_request (pose_request),
    .arm_stop     (arm_stop),
    .report_code  (report_code),
    .running      (running)
);
